// ===== hdl/ebalu_pkg.sv =====
// ---------------------------------------------------------------------------
// ebalu_pkg
// Shared types and constants for the eight-bit ALU with Z/N/H/C flags.
// ---------------------------------------------------------------------------
package ebalu_pkg;

    localparam int unsigned KIND_W   = 5;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FLAGS_W  = 4;
    localparam int unsigned BITSEL_W = 3;

    // Flag nibble positions: Z N H C from the top bit down
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD = 5'd0,
        OP_ADC = 5'd1,
        OP_SUB = 5'd2,
        OP_SBC = 5'd3,
        OP_AND = 5'd4,
        OP_OR  = 5'd5,
        OP_XOR = 5'd6,
        OP_CP  = 5'd7,
        OP_INC = 5'd8,
        OP_DEC = 5'd9,
        OP_RLC = 5'd10,
        OP_RL  = 5'd11,
        OP_RRC = 5'd12,
        OP_RR  = 5'd13,
        OP_SLA = 5'd14,
        OP_SRA = 5'd15,
        OP_SRL = 5'd16,
        OP_BIT = 5'd17,
        OP_SET = 5'd18,
        OP_RES = 5'd19
    } t_alu_op;

    // One operation as held in the input register
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   acc_value;
        logic [BYTE_W-1:0]   operand_value;
        logic [FLAGS_W-1:0]  flags_in;
        logic [BITSEL_W-1:0] bit_select;
    } t_alu_req;

    // One result as held in the result register
    typedef struct packed {
        logic [BYTE_W-1:0]  result_value;
        logic [FLAGS_W-1:0] flags_out;
        logic               writes_result;
    } t_alu_rsp;

    localparam int unsigned REQ_W = $bits(t_alu_req);
    localparam int unsigned RSP_W = $bits(t_alu_rsp);

endpackage

// ===== hdl/ebalu_stage.sv =====
// ---------------------------------------------------------------------------
// ebalu_stage
// One valid/ready register stage; takes a new transfer whenever it is empty
// or its content leaves in the same cycle.
// ---------------------------------------------------------------------------
module ebalu_stage #(
    parameter int unsigned DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    logic              r_valid;
    logic [DATA_W-1:0] r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset; load only on a transfer
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== hdl/ebalu_exec.sv =====
// ---------------------------------------------------------------------------
// ebalu_exec
// Combinational datapath: result byte, flag nibble and write enable for one
// operation.
// ---------------------------------------------------------------------------
module ebalu_exec (
    input  ebalu_pkg::t_alu_req i_req,
    output ebalu_pkg::t_alu_rsp o_rsp
);
    import ebalu_pkg::*;

    logic [BYTE_W-1:0]  a;
    logic [BYTE_W-1:0]  v;
    logic [FLAGS_W-1:0] f;
    logic               cin;
    logic [BYTE_W-1:0]  bmask;
    logic               use_c_add;
    logic               use_c_sub;
    logic [BYTE_W:0]    sum9;
    logic [4:0]         hsum;
    logic [BYTE_W:0]    dif9;
    logic [4:0]         hdif;
    logic [BYTE_W-1:0]  res;
    logic [FLAGS_W-1:0] fo;
    logic               wr;
    logic               zr;

    assign a     = i_req.acc_value;
    assign v     = i_req.operand_value;
    assign f     = i_req.flags_in;
    assign cin   = f[FLAG_C];
    assign bmask = 8'b1 << i_req.bit_select;

    assign use_c_add = (t_alu_op'(i_req.kind) == OP_ADC) && cin;
    assign use_c_sub = (t_alu_op'(i_req.kind) == OP_SBC) && cin;

    // Shared adder and subtractor, nine bits wide for carry and borrow
    assign sum9 = {1'b0, a} + {1'b0, v} + {8'd0, use_c_add};
    assign hsum = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_c_add};
    assign dif9 = {1'b0, a} - {1'b0, v} - {8'd0, use_c_sub};
    assign hdif = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_c_sub};

    always_comb begin
        res = '0;
        fo  = f;
        wr  = 1'b1;
        unique case (t_alu_op'(i_req.kind))
            OP_ADD, OP_ADC: begin
                res = sum9[7:0];
                fo  = {1'b0, 1'b0, hsum[4], sum9[8]};
            end
            OP_SUB, OP_SBC: begin
                res = dif9[7:0];
                fo  = {1'b0, 1'b1, hdif[4], dif9[8]};
            end
            OP_CP: begin
                res = dif9[7:0];
                fo  = {1'b0, 1'b1, hdif[4], dif9[8]};
            end
            OP_AND: begin
                res = a & v;
                fo  = 4'b0010;
            end
            OP_OR: begin
                res = a | v;
                fo  = 4'b0000;
            end
            OP_XOR: begin
                res = a ^ v;
                fo  = 4'b0000;
            end
            OP_INC: begin
                res = v + 8'd1;
                fo  = {1'b0, 1'b0, (v[3:0] == 4'hF), cin};
            end
            OP_DEC: begin
                res = v - 8'd1;
                fo  = {1'b0, 1'b1, (v[3:0] == 4'h0), cin};
            end
            OP_RLC: begin
                res = {v[6:0], v[7]};
                fo  = {3'b000, v[7]};
            end
            OP_RL: begin
                res = {v[6:0], cin};
                fo  = {3'b000, v[7]};
            end
            OP_RRC: begin
                res = {v[0], v[7:1]};
                fo  = {3'b000, v[0]};
            end
            OP_RR: begin
                res = {cin, v[7:1]};
                fo  = {3'b000, v[0]};
            end
            OP_SLA: begin
                res = {v[6:0], 1'b0};
                fo  = {3'b000, v[7]};
            end
            OP_SRA: begin
                res = {v[7], v[7:1]};
                fo  = {3'b000, v[0]};
            end
            OP_SRL: begin
                res = {1'b0, v[7:1]};
                fo  = {3'b000, v[0]};
            end
            OP_BIT: begin
                res = v;
                fo  = {((v & bmask) == 8'd0), 1'b0, 1'b1, cin};
                wr  = 1'b0;
            end
            OP_SET: begin
                res = v | bmask;
            end
            OP_RES: begin
                res = v & ~bmask;
            end
            default: begin
                res = '0;
                fo  = f;
                wr  = 1'b0;
            end
        endcase
    end

    // Zero flag from the computed byte, for the arithmetic, logic, rotate/shift and compare kinds
    assign zr = (res == 8'd0);

    always_comb begin
        o_rsp.result_value  = res;
        o_rsp.flags_out     = fo;
        o_rsp.writes_result = wr;
        unique case (t_alu_op'(i_req.kind))
            OP_BIT, OP_SET, OP_RES: begin
                o_rsp.flags_out = fo;
            end
            OP_CP: begin
                o_rsp.flags_out[FLAG_Z] = zr;
                o_rsp.result_value      = a;
                o_rsp.writes_result     = 1'b0;
            end
            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_OR, OP_XOR, OP_INC, OP_DEC,
            OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
                o_rsp.flags_out[FLAG_Z] = zr;
            end
            default: begin
                o_rsp.flags_out = fo;
            end
        endcase
    end

endmodule

// ===== hdl/eight_bit_alu_with_flags_core.sv =====
// ---------------------------------------------------------------------------
// eight_bit_alu_with_flags_core
// Eight-bit ALU with Z/N/H/C flags: arithmetic, logic, rotate/shift and
// bit operations, one operation per stream transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Send one operation per transfer on the s_axis channel: the operation
//   code in s_axis_tuser, the operands, flag nibble and bit index in
//   s_axis_tdata. Each transfer yields exactly one result transfer on the
//   m_axis channel, in order: result byte and new flags in m_axis_tdata,
//   the write enable for the result byte in m_axis_tuser.
//   The input register loads at the input transfer; the result register
//   loads from it through the datapath once it is free, and the result
//   transfer follows from the result register. Throughput is one operation
//   per cycle while m_axis_tready stays high; each register takes a new
//   item in the cycle its content leaves.
//   When the receiver holds m_axis_tready low, the result register holds
//   its item and the input register still takes one more item; after that
//   s_axis_tready drops until the result leaves. Both sides keep their
//   data stable while stalled.
//   Reset (i_rst_n low, synchronous) empties both registers; the block
//   holds no other state. Unused operation codes give a zero result byte,
//   the incoming flags unchanged and no write.
// ---------------------------------------------------------------------------
module eight_bit_alu_with_flags_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Operation in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // acc_value[7:0], operand_value[15:8],
                                       // flags_in[19:16], bit_select[22:20], zero pad
    input  logic [4:0]  s_axis_tuser,  // kind[4:0]
    // Result out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // result_value[7:0], flags_out[11:8], zero pad
    output logic [0:0]  m_axis_tuser   // writes_result[0]
);
    import ebalu_pkg::*;

    t_alu_req             req_in;
    t_alu_req             req_q;
    logic [REQ_W-1:0]     req_q_bits;
    logic                 req_valid;
    logic                 req_ready;
    t_alu_rsp             rsp_d;
    logic [RSP_W-1:0]     rsp_q_bits;
    t_alu_rsp             rsp_q;

    // Unpack the stream fields into the request structure
    assign req_in.kind          = s_axis_tuser;
    assign req_in.acc_value     = s_axis_tdata[7:0];
    assign req_in.operand_value = s_axis_tdata[15:8];
    assign req_in.flags_in      = s_axis_tdata[19:16];
    assign req_in.bit_select    = s_axis_tdata[22:20];

    // Input register
    ebalu_stage #(
        .DATA_W (REQ_W)
    ) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (req_in),
        .o_valid (req_valid),
        .i_ready (req_ready),
        .o_data  (req_q_bits)
    );

    assign req_q = t_alu_req'(req_q_bits);

    // Datapath between the two registers
    ebalu_exec u_exec (
        .i_req (req_q),
        .o_rsp (rsp_d)
    );

    // Result register; advance while empty or while the receiver takes
    ebalu_stage #(
        .DATA_W (RSP_W)
    ) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_data  (rsp_d),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (rsp_q_bits)
    );

    assign rsp_q           = t_alu_rsp'(rsp_q_bits);
    assign m_axis_tdata    = {4'd0, rsp_q.flags_out, rsp_q.result_value};
    assign m_axis_tuser[0] = rsp_q.writes_result;

`ifndef SYNTHESIS
    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // An item in the input register with a free result register moves on
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_valid && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("item lost between input and result register");

    // Both registers full and receiver stalled: no new transfer may enter
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while pipeline full");
`endif

endmodule
